// ===== rtl/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier curve sampler package
// Shared constants, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int MIN_W      = 7;
  localparam int SPACING_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [MIN_W-1:0]     MIN_SAMPLES_RESET    = 7'd20;
  localparam logic [SPACING_W-1:0] SAMPLE_SPACING_RESET = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SAMPLES    = 1'b0,
    CFG_SAMPLE_SPACING = 1'b1
  } cfg_index_t;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_SQUARE    = 12'b0000_0000_0010,
    ST_SQRT_GO   = 12'b0000_0000_0100,
    ST_SQRT_WAIT = 12'b0000_0000_1000,
    ST_DIVQ_GO   = 12'b0000_0001_0000,
    ST_DIVQ_WAIT = 12'b0000_0010_0000,
    ST_COUNT     = 12'b0000_0100_0000,
    ST_DIVT_GO   = 12'b0000_1000_0000,
    ST_DIVT_WAIT = 12'b0001_0000_0000,
    ST_SETUP     = 12'b0010_0000_0000,
    ST_RUN       = 12'b0100_0000_0000,
    ST_DRAIN     = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic sqrt_start;
    logic div_start;
    logic div_step_sel;
    logic set_count;
    logic set_step;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic issue_fire;
    logic issue_last;
    logic pipe_empty;
  } status_t;

endpackage

// ===== rtl/bcs_curve_if.sv =====
// ----------------------------------------------------------------------------
// Curve channel
// Valid/ready channel carrying the four control points of one curve.
// ----------------------------------------------------------------------------
interface bcs_curve_if #(
  parameter int COORD_W = 16
) ();
  logic               valid;
  logic               ready;
  logic signed [COORD_W-1:0] x0;
  logic signed [COORD_W-1:0] y0;
  logic signed [COORD_W-1:0] x1;
  logic signed [COORD_W-1:0] y1;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic signed [COORD_W-1:0] x3;
  logic signed [COORD_W-1:0] y3;

  modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
  modport sink   (input valid, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

// ===== rtl/bcs_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sampled curve point.
// ----------------------------------------------------------------------------
interface bcs_sample_if #(
  parameter int COORD_W = 16,
  parameter int IDX_W   = 6
) ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic [IDX_W-1:0]          sample_index;
  logic                      last;

  modport source (output valid, px, py, sample_index, last, input ready);
  modport sink   (input valid, px, py, sample_index, last, output ready);
endinterface

// ===== rtl/bcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// Integer square root
// Restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bcs_sqrt #(
  parameter int SW = 35,
  parameter int RW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] radicand,
  output logic          done,
  output logic [RW-1:0] root
);
  localparam int BP = ((SW - 1) / 2) * 2;

  logic          busy;
  logic [SW-1:0] v;
  logic [SW-1:0] res;
  logic [SW-1:0] bitm;
  logic [SW-1:0] trial;

  assign trial = res + bitm;
  assign root  = res[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bitm >> 2) == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= SW'(1) << BP;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// ===== rtl/bcs_div.sv =====
// ----------------------------------------------------------------------------
// Unsigned divider
// Restoring divider, one quotient bit per cycle, giving quotient and
// remainder.
// ----------------------------------------------------------------------------
module bcs_div #(
  parameter int NW = 18,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dreg;
  logic [DW:0]   rreg;
  logic [DW:0]   rsh;

  assign rsh = {rreg[DW-1:0], quo[NW-1]};
  assign rem = rreg[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rreg <= '0;
      dreg <= den;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (rsh >= {1'b0, dreg}) begin
        rreg <= rsh - {1'b0, dreg};
        quo  <= {quo[NW-2:0], 1'b1};
      end else begin
        rreg <= rsh;
        quo  <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/bcs_datapath.sv =====
// ----------------------------------------------------------------------------
// Bezier sampler datapath
// Configuration registers, coefficient set-up, distance and count
// arithmetic, parameter stepping and the four-stage point pipeline.
// ----------------------------------------------------------------------------
module bcs_datapath #(
  parameter int COORD_W     = 16,
  parameter int T_FRAC      = 16,
  parameter int MAX_SAMPLES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  bcs_pkg::cmd_t                  cmd,
  output bcs_pkg::status_t               status,
  bcs_curve_if.sink                      curve,
  bcs_sample_if.source                   sample
);
  localparam int DS    = (COORD_W > 31) ? COORD_W - 31 : 0;
  localparam int AW    = COORD_W + 1 - DS;
  localparam int SW    = 2 * AW + 1;
  localparam int RW    = AW + 1;
  localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
  localparam int IDXW  = $clog2(MAX_SAMPLES);
  localparam int DW    = (bcs_pkg::SPACING_W + 4 > CNTW + 1) ?
                         bcs_pkg::SPACING_W + 4 : CNTW + 1;
  localparam int NW    = (RW > T_FRAC + 2) ? RW : T_FRAC + 2;
  localparam int QW    = (NW > bcs_pkg::MIN_W) ? NW : bcs_pkg::MIN_W;
  localparam int CFW   = COORD_W + 4;
  localparam int TW    = T_FRAC + 1;
  localparam int PRW   = CFW + TW + 1;
  localparam int SUMW  = PRW + 2;
  localparam int RNDW  = SUMW - T_FRAC;
  localparam int PW    = RNDW + 1;
  localparam int RW2   = CNTW + 2;

  localparam logic signed [SUMW-1:0] SUM_HALF = SUMW'(1) <<< (T_FRAC - 1);
  localparam logic [2*TW-1:0]        T_HALF   = (2*TW)'(1) << (T_FRAC - 1);
  localparam logic signed [PW-1:0]   C_HI     = PW'((65'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [PW-1:0]   C_LO     = -C_HI - PW'(1);

  // Configuration.
  logic [bcs_pkg::MIN_W-1:0]     min_samples;
  logic [bcs_pkg::SPACING_W-1:0] sample_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples    <= bcs_pkg::MIN_SAMPLES_RESET;
      sample_spacing <= bcs_pkg::SAMPLE_SPACING_RESET;
    end else if (cfg_we) begin
      unique case (bcs_pkg::cfg_index_t'(cfg_index))
        bcs_pkg::CFG_MIN_SAMPLES:    min_samples    <= cfg_data[bcs_pkg::MIN_W-1:0];
        bcs_pkg::CFG_SAMPLE_SPACING: sample_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficients and end-point distance.
  logic signed [COORD_W-1:0] p0x, p0y;
  logic signed [CFW-1:0]     ax, bx, cx, ay, by, cy;
  logic signed [CFW-1:0]     ax_n, bx_n, cx_n, ay_n, by_n, cy_n;
  logic signed [CFW-1:0]     ex0, ex1, ex2, ex3, ey0, ey1, ey2, ey3;
  logic signed [CFW-1:0]     d1x, d2x, d1y, d2y;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          mx, my;
  logic [AW-1:0]             adx, ady;
  logic [SW-1:0]             sumsq;

  assign ex0 = CFW'(curve.x0);
  assign ex1 = CFW'(curve.x1);
  assign ex2 = CFW'(curve.x2);
  assign ex3 = CFW'(curve.x3);
  assign ey0 = CFW'(curve.y0);
  assign ey1 = CFW'(curve.y1);
  assign ey2 = CFW'(curve.y2);
  assign ey3 = CFW'(curve.y3);

  always_comb begin
    d1x  = ex1 - ex0;
    d2x  = ex2 - ex1;
    cx_n = (d1x <<< 1) + d1x;
    bx_n = (d2x <<< 1) + d2x - cx_n;
    ax_n = ex3 - ex0 - cx_n - bx_n;
    d1y  = ey1 - ey0;
    d2y  = ey2 - ey1;
    cy_n = (d1y <<< 1) + d1y;
    by_n = (d2y <<< 1) + d2y - cy_n;
    ay_n = ey3 - ey0 - cy_n - by_n;
    dx   = (COORD_W+1)'(curve.x3) - (COORD_W+1)'(curve.x0);
    dy   = (COORD_W+1)'(curve.y3) - (COORD_W+1)'(curve.y0);
    mx   = dx[COORD_W] ? -dx : dx;
    my   = dy[COORD_W] ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0x <= curve.x0;
      p0y <= curve.y0;
      ax  <= ax_n;
      bx  <= bx_n;
      cx  <= cx_n;
      ay  <= ay_n;
      by  <= by_n;
      cy  <= cy_n;
      adx <= AW'(mx >> DS);
      ady <= AW'(my >> DS);
    end
    if (cmd.square) begin
      sumsq <= SW'(adx * adx) + SW'(ady * ady);
    end
  end

  // Square root and shared divider.
  logic [RW-1:0]   root;
  logic [NW-1:0]   div_num, div_quo;
  logic [DW-1:0]   div_den, div_rem, dist_den;
  logic [DW-1:0]   sp16;
  logic [CNTW-1:0] m;
  logic [CNTW:0]   twom;

  bcs_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .radicand(sumsq),
    .done(status.sqrt_done), .root(root)
  );

  assign twom = {m, 1'b0};

  always_comb begin
    sp16     = DW'({(sample_spacing == '0) ? bcs_pkg::SPACING_W'(1) : sample_spacing,
                    4'b0000} >> DS);
    dist_den = (sp16 == '0) ? DW'(1) : sp16;
    div_num  = cmd.div_step_sel ? NW'(1) << (T_FRAC + 1) : NW'(root);
    div_den  = cmd.div_step_sel ? DW'(twom) : dist_den;
  end

  bcs_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(div_den),
    .done(status.div_done), .quo(div_quo), .rem(div_rem)
  );

  // Sample count.
  logic [bcs_pkg::MIN_W-1:0] nmin;
  logic [QW-1:0]             nq;
  logic [QW-1:0]             nsat;

  always_comb begin
    nmin = (min_samples < bcs_pkg::MIN_W'(2)) ? bcs_pkg::MIN_W'(2) : min_samples;
    nq   = (QW'(div_quo) > QW'(nmin)) ? QW'(div_quo) : QW'(nmin);
    nsat = (nq > QW'(MAX_SAMPLES)) ? QW'(MAX_SAMPLES) : nq;
  end

  always_ff @(posedge clk) begin
    if (cmd.set_count) begin
      m <= CNTW'(nsat - QW'(1));
    end
  end

  // Parameter stepping: t = round(2^T_FRAC * i / m) kept as quotient and remainder.
  logic [TW-1:0]   step_q, t;
  logic [TW-1:0]   t_n;
  logic [RW2-1:0]  step_r, r, r_s, r_n;
  logic [IDXW-1:0] idx;
  logic            adv;
  logic            v1, v2, v3, v4;

  assign adv = !v4 || sample.ready;
  assign status.issue_fire = cmd.issue && adv;
  assign status.issue_last = (idx == m[IDXW-1:0]);
  assign status.pipe_empty = !(v1 || v2 || v3 || v4);

  always_comb begin
    r_s = r + step_r;
    if (r_s >= RW2'(twom)) begin
      r_n = r_s - RW2'(twom);
      t_n = t + step_q + TW'(1);
    end else begin
      r_n = r_s;
      t_n = t + step_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_step) begin
      step_q <= div_quo[TW-1:0];
      step_r <= RW2'(div_rem);
      t      <= '0;
      r      <= RW2'(m);
      idx    <= '0;
    end else if (status.issue_fire) begin
      t   <= t_n;
      r   <= r_n;
      idx <= idx + IDXW'(1);
    end
  end

  // Point pipeline.
  logic [TW-1:0]          t1, t1b, t2a, t2b, t3a;
  logic [2*TW-1:0]        tt1, tt2, tt1h, tt2h;
  logic [IDXW-1:0]        i1, i2, i3;
  logic                   l1, l2, l3;
  logic signed [PRW-1:0]  pax, pbx, pcx, pay, pby, pcy;
  logic signed [SUMW-1:0] sx, sy;
  logic signed [RNDW-1:0] rx, ry;
  logic signed [PW-1:0]   qx, qy;

  assign tt1h = tt1 + T_HALF;
  assign t2a  = tt1h[T_FRAC+TW-1:T_FRAC];
  assign tt2h = tt2 + T_HALF;
  assign t3a  = tt2h[T_FRAC+TW-1:T_FRAC];

  always_comb begin
    sx = SUMW'(pax) + SUMW'(pbx) + SUMW'(pcx) + SUM_HALF;
    sy = SUMW'(pay) + SUMW'(pby) + SUMW'(pcy) + SUM_HALF;
    rx = RNDW'(sx >>> T_FRAC);
    ry = RNDW'(sy >>> T_FRAC);
    qx = PW'(p0x) + PW'(rx);
    qy = PW'(p0y) + PW'(ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1  <= t;
      tt1 <= t * t;
      i1  <= idx;
      l1  <= status.issue_last;

      t2b <= t2a;
      tt2 <= t2a * t1;
      t1b <= t1;
      i2  <= i1;
      l2  <= l1;

      pax <= ax * $signed({1'b0, t3a});
      pbx <= bx * $signed({1'b0, t2b});
      pcx <= cx * $signed({1'b0, t1b});
      pay <= ay * $signed({1'b0, t3a});
      pby <= by * $signed({1'b0, t2b});
      pcy <= cy * $signed({1'b0, t1b});
      i3  <= i2;
      l3  <= l2;

      sample.px           <= (qx > C_HI) ? C_HI[COORD_W-1:0] :
                             (qx < C_LO) ? C_LO[COORD_W-1:0] : qx[COORD_W-1:0];
      sample.py           <= (qy > C_HI) ? C_HI[COORD_W-1:0] :
                             (qy < C_LO) ? C_LO[COORD_W-1:0] : qy[COORD_W-1:0];
      sample.sample_index <= i3;
      sample.last         <= l3;
    end
  end

  assign sample.valid = v4;

endmodule

// ===== rtl/bcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bezier sampler controller
// One-hot sequencer stepping one curve through set-up, count, stepping and
// sample issue.
// ----------------------------------------------------------------------------
module bcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             curve_valid,
  output logic             curve_ready,
  input  bcs_pkg::status_t status,
  output bcs_pkg::cmd_t    cmd
);
  bcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd              = '0;
    curve_ready      = 1'b0;
    unique case (state)
      bcs_pkg::ST_IDLE: begin
        curve_ready = 1'b1;
        cmd.load    = curve_valid;
        if (curve_valid) state_next = bcs_pkg::ST_SQUARE;
      end
      bcs_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = bcs_pkg::ST_SQRT_GO;
      end
      bcs_pkg::ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = bcs_pkg::ST_SQRT_WAIT;
      end
      bcs_pkg::ST_SQRT_WAIT: begin
        if (status.sqrt_done) state_next = bcs_pkg::ST_DIVQ_GO;
      end
      bcs_pkg::ST_DIVQ_GO: begin
        cmd.div_start = 1'b1;
        state_next    = bcs_pkg::ST_DIVQ_WAIT;
      end
      bcs_pkg::ST_DIVQ_WAIT: begin
        if (status.div_done) state_next = bcs_pkg::ST_COUNT;
      end
      bcs_pkg::ST_COUNT: begin
        cmd.set_count = 1'b1;
        state_next    = bcs_pkg::ST_DIVT_GO;
      end
      bcs_pkg::ST_DIVT_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_step_sel = 1'b1;
        state_next       = bcs_pkg::ST_DIVT_WAIT;
      end
      bcs_pkg::ST_DIVT_WAIT: begin
        if (status.div_done) state_next = bcs_pkg::ST_SETUP;
      end
      bcs_pkg::ST_SETUP: begin
        cmd.set_step = 1'b1;
        state_next   = bcs_pkg::ST_RUN;
      end
      bcs_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.issue_fire && status.issue_last) state_next = bcs_pkg::ST_DRAIN;
      end
      bcs_pkg::ST_DRAIN: begin
        if (status.pipe_empty) state_next = bcs_pkg::ST_IDLE;
      end
      default: state_next = bcs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/cubic_bezier_curve_sampler.sv =====
// The first point follows the curve transfer once the bit-serial square root and
// the two divider passes are done. Points stream at one per cycle while the output is
// taken; a new curve is accepted only once the previous one has fully drained.
// Reset (synchronous, active high) restores the registers to 20 and 10 and empties the
// pipeline; no clearing pass follows.
// ----------------------------------------------------------------------------
// Cubic Bezier curve sampler
// Accepts one curve, sizes its sample count from the end-point distance and
// streams points at evenly spaced parameter values along it.
// ----------------------------------------------------------------------------
module cubic_bezier_curve_sampler #(
  parameter int MAX_SAMPLES = 64,
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data,
  bcs_curve_if.sink                      curve,
  bcs_sample_if.source                   sample
);
  localparam int IDXW = $clog2(MAX_SAMPLES);

  bcs_pkg::cmd_t    cmd;
  bcs_pkg::status_t status;

  bcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .curve_valid(curve.valid), .curve_ready(curve.ready),
    .status(status), .cmd(cmd)
  );

  bcs_datapath #(
    .COORD_W(COORD_WIDTH), .T_FRAC(T_FRAC_BITS), .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .status(status), .curve(curve),
    .sample(sample)
  );

  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    curve.ready |-> !sample.valid)
    else $error("curve accepted while samples are outstanding");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (curve.valid && curve.ready) |=> !curve.ready)
    else $error("controller did not leave idle after a curve transfer");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready && !sample.last) ##1 sample.valid |->
      sample.sample_index == IDXW'($past(sample.sample_index) + 1'b1))
    else $error("sample index did not advance by one");

  a_last_not_first: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.last) |-> sample.sample_index != '0)
    else $error("final sample flagged at index zero");

endmodule

// ===== sim/cubic_bezier_curve_sampler_tb.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier curve sampler testbench
// Sends curves to the sampler, works out the expected points of each curve
// from the control points and the current registers, and compares every point
// transfer field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module cubic_bezier_curve_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] x0, y0, x1, y1, x2, y2, x3, y3;
  } curve_t;

  typedef struct {
    logic signed [15:0] px, py;
    logic [5:0]         sample_index;
    logic               last;
  } point_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index = bcs_pkg::CFG_MIN_SAMPLES;
  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bcs_curve_if  #(.COORD_W(16)) curve_ch ();
  bcs_sample_if #(.COORD_W(16), .IDX_W(6)) sample_ch ();

  cubic_bezier_curve_sampler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .curve(curve_ch.sink), .sample(sample_ch.source)
  );

  curve_t pending_curves[$];
  point_t expected_points[$];
  logic [6:0] min_count = 7'd20;
  logic [7:0] spacing = 8'd10;
  int   errors = 0;
  int   send_gap = 0;
  int   take_gap = 0;
  int   hold_cycles = 0;
  bit   pause_sender = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint round_half_up(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_points(curve_t c);
    longint dx, dy, root, q, n, m, t, t2, t3;
    longint ax, bx, cx, ay, by, cy, sp;
    point_t p;
    dx = longint'(c.x3) - c.x0;
    dy = longint'(c.y3) - c.y0;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    root = int_sqrt(dx * dx + dy * dy);
    sp = (spacing == 0) ? 1 : spacing;
    q = root / (16 * sp);
    n = (min_count < 2) ? 2 : min_count;
    if (q > n) n = q;
    if (n > 64) n = 64;
    cx = 3 * (longint'(c.x1) - c.x0);
    bx = 3 * (longint'(c.x2) - c.x1) - cx;
    ax = longint'(c.x3) - c.x0 - cx - bx;
    cy = 3 * (longint'(c.y1) - c.y0);
    by = 3 * (longint'(c.y2) - c.y1) - cy;
    ay = longint'(c.y3) - c.y0 - cy - by;
    m = n - 1;
    for (longint i = 0; i < n; i++) begin
      t = ((i << 17) + m) / (2 * m);
      t2 = round_half_up(t * t);
      t3 = round_half_up(t2 * t);
      p.px = clamp16(c.x0 + round_half_up(ax * t3 + bx * t2 + cx * t));
      p.py = clamp16(c.y0 + round_half_up(ay * t3 + by * t2 + cy * t));
      p.sample_index = i[5:0];
      p.last = (i == m);
      expected_points.push_back(p);
    end
  endtask

  initial begin
    curve_ch.valid = 1'b0;
    {curve_ch.x0, curve_ch.y0, curve_ch.x1, curve_ch.y1} = '0;
    {curve_ch.x2, curve_ch.y2, curve_ch.x3, curve_ch.y3} = '0;
    sample_ch.ready = 1'b0;
  end

  // The driver predicts each curve at its transfer, so the registers it sees are current.
  always @(posedge clk) begin
    if (!rst) begin
      if (curve_ch.valid && curve_ch.ready) begin
        predict_points(pending_curves.pop_front());
      end
      if ((!curve_ch.valid || curve_ch.ready)) begin
        if (curve_ch.valid && curve_ch.ready) send_gap = gap_len();
        if (send_gap > 0 && !pause_sender) send_gap--;
        if (pending_curves.size() > 0 && send_gap == 0 && !pause_sender
            && !(curve_ch.valid && curve_ch.ready && pending_curves.size() == 0)) begin
          curve_ch.valid <= 1'b1;
          curve_ch.x0 <= pending_curves[0].x0;
          curve_ch.y0 <= pending_curves[0].y0;
          curve_ch.x1 <= pending_curves[0].x1;
          curve_ch.y1 <= pending_curves[0].y1;
          curve_ch.x2 <= pending_curves[0].x2;
          curve_ch.y2 <= pending_curves[0].y2;
          curve_ch.x3 <= pending_curves[0].x3;
          curve_ch.y3 <= pending_curves[0].y3;
        end else begin
          curve_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        if (expected_points.size() == 0) begin
          $error("point transfer with none expected");
          errors++;
        end else begin
          point_t e;
          e = expected_points.pop_front();
          if (sample_ch.px !== e.px) begin
            $error("px expected %0d actual %0d", e.px, sample_ch.px); errors++;
          end
          if (sample_ch.py !== e.py) begin
            $error("py expected %0d actual %0d", e.py, sample_ch.py); errors++;
          end
          if (sample_ch.sample_index !== e.sample_index) begin
            $error("sample_index expected %0d actual %0d", e.sample_index,
                   sample_ch.sample_index); errors++;
          end
          if (sample_ch.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, sample_ch.last); errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        sample_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        sample_ch.ready <= 1'b0;
      end else begin
        sample_ch.ready <= 1'b1;
        take_gap = gap_len();
      end
    end
  end

  function automatic curve_t random_curve(bit short_span);
    curve_t c;
    c.x0 = 16'($urandom); c.y0 = 16'($urandom);
    c.x1 = 16'($urandom); c.y1 = 16'($urandom);
    c.x2 = 16'($urandom); c.y2 = 16'($urandom);
    if (short_span) begin
      c.x3 = c.x0 + $signed(16'($urandom_range(0, 4000)) - 16'sd2000);
      c.y3 = c.y0 + $signed(16'($urandom_range(0, 4000)) - 16'sd2000);
    end else begin
      c.x3 = 16'($urandom); c.y3 = 16'($urandom);
    end
    return c;
  endfunction

  task automatic write_reg(bcs_pkg::cfg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bcs_pkg::CFG_MIN_SAMPLES) min_count = val[6:0];
    else spacing = val;
  endtask

  task automatic wait_drained();
    while (pending_curves.size() > 0 || curve_ch.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_curve(logic signed [15:0] a0, b0, a1, b1, a2, b2, a3, b3);
    curve_t c;
    c.x0 = a0; c.y0 = b0; c.x1 = a1; c.y1 = b1;
    c.x2 = a2; c.y2 = b2; c.x3 = a3; c.y3 = b3;
    pending_curves.push_back(c);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed curves at reset settings: degenerate, extremes, overflow of points.
    add_curve(0, 0, 0, 0, 0, 0, 0, 0);
    add_curve(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    add_curve(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768);
    add_curve(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
    add_curve(100, 200, 300, 400, 500, 600, 700, 800);
    add_curve(0, 0, 32767, -32768, -32768, 32767, 1600, 0);
    wait_drained();
    write_reg(bcs_pkg::CFG_MIN_SAMPLES, 8'd0);
    write_reg(bcs_pkg::CFG_SAMPLE_SPACING, 8'd0);
    add_curve(0, 0, 0, 0, 0, 0, 0, 0);
    add_curve(0, 0, 10, 10, 20, 20, 480, 0);
    add_curve(-5, 7, 3, -3, 8, 8, 15, 15);
    wait_drained();
    write_reg(bcs_pkg::CFG_MIN_SAMPLES, 8'd127);
    write_reg(bcs_pkg::CFG_SAMPLE_SPACING, 8'd255);
    add_curve(1, 2, 3, 4, 5, 6, 7, 8);
    add_curve(-32768, 0, 0, 0, 0, 0, 32767, 0);
    wait_drained();
    write_reg(bcs_pkg::CFG_MIN_SAMPLES, 8'd2);
    write_reg(bcs_pkg::CFG_SAMPLE_SPACING, 8'd1);
    add_curve(0, 0, 1000, 1000, -1000, 2000, 320, 0);
    add_curve(-32768, -32768, 0, 0, 0, 0, 32767, 32767);
    wait_drained();
    // Random phases; the receiver holds off in the first to fill the block.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(bcs_pkg::CFG_MIN_SAMPLES, (ph == 0) ? 8'd64 : 8'($urandom_range(0, 127)));
      write_reg(bcs_pkg::CFG_SAMPLE_SPACING,
                (ph == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
      if (ph == 0) hold_cycles = 400;
      for (int k = 0; k < 75; k++)
        pending_curves.push_back(random_curve($urandom_range(0, 9) < 8));
      if (ph == 2) begin
        while (pending_curves.size() > 40) @(posedge clk);
        pause_sender = 1'b1;
        while (curve_ch.valid || expected_points.size() > 0) @(posedge clk);
        pause_sender = 1'b0;
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule
